>>> design/wsp_pkg.sv
// package for the world-to-screen projection block
// widths, operation codes, channel payloads and the controller state type; no dependencies
package wsp_pkg;

	localparam int WORD_W  = 32;
	localparam int CFG_W   = 14;
	localparam int IDX_W   = 4;
	localparam int CFG_IDX_W = 1;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_PROJECT = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_VIEW_WIDTH  = 1'b0,
		REG_VIEW_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] VIEW_WIDTH_RST  = 14'd1920;
	localparam logic [CFG_W-1:0] VIEW_HEIGHT_RST = 14'd1080;

	// request and result payloads of the two channels
	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         entry_index;
		logic signed [WORD_W-1:0] entry_value;
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] pos_z;
	} proj_req_t;

	typedef struct packed {
		logic                     visible;
		logic signed [WORD_W-1:0] screen_x;
		logic signed [WORD_W-1:0] screen_y;
	} screen_pt_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC_LOAD,
		ST_MAC,
		ST_MAC_DONE,
		ST_CHECK,
		ST_DIV_X_LOAD,
		ST_DIV_X,
		ST_DIV_Y_LOAD,
		ST_DIV_Y,
		ST_SCALE_X_LOAD,
		ST_SCALE_X,
		ST_SCALE_Y_LOAD,
		ST_SCALE_Y,
		ST_OUT
	} state_t;

endpackage

>>> design/wsp_if.sv
// valid/ready channel interface carrying one generic payload
// depends on nothing; payload type given by parameter
interface wsp_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/wsp_serial_mul.sv
// bit-serial signed multiplier: one multiplier bit a cycle, shift-add
// depends on wsp_pkg; product is exact, a_w + b_w bits
module wsp_serial_mul
	import wsp_pkg::*;
#(
	parameter int A_W = 32,
	parameter int B_W = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [A_W-1:0]  a,
	input  logic signed [B_W-1:0]  b,
	output logic                   done,
	output logic signed [A_W+B_W-1:0] prod
);
	localparam int P_W = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic signed [P_W-1:0] acc_q;
	logic signed [P_W-1:0] mcand_q;
	logic [B_W-1:0]        mplier_q;
	logic                  last;

	assign last = (cnt_q == CNT_W'(B_W - 1));

	// multiplier bit of weight 2^(B_W-1) carries negative weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= P_W'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= last ? acc_q - mcand_q : acc_q + mcand_q;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= busy_q && last;
	end

	always_comb begin
		prod = acc_q;
	end
endmodule

>>> design/wsp_serial_div.sv
// restoring divider, one quotient bit a cycle, unsigned
// depends on wsp_pkg; numerator N_W bits, denominator D_W bits
module wsp_serial_div
	import wsp_pkg::*;
#(
	parameter int N_W = 64,
	parameter int D_W = 40
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [N_W-1:0] quo
);
	localparam int CNT_W = $clog2(N_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W:0]     rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   den_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;

	assign trial = {rem_q[D_W-1:0], quo_q[N_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && (cnt_q == CNT_W'(N_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(N_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[D_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[N_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[N_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule

>>> design/world_to_screen_projection.sv
// world-to-screen projection top level: matrix store, sequencer, serial units
// depends on wsp_pkg, wsp_if, wsp_serial_mul, wsp_serial_div
//
// usage
//  - in channel (sink): op, entry_index, entry_value, pos_x, pos_y, pos_z
//  - out channel (source): visible, screen_x, screen_y; one per project request
//  - cfg port: cfg_we, cfg_idx, cfg_data; index 0 view width, 1 view height
//  - a load request writes one matrix entry while the block stays idle
//  - a project request runs nine signed multiplies on one bit-serial
//    multiplier (each with load and accumulate steps), two divides by
//    clip w on one restoring divider (67 quotient bits each), then two
//    viewport scales on the multiplier
//  - a visible result is offered once the multiplies, divides and scales are done;
//    a hidden one straight after the clip w check (no divides, no scales)
//  - the next request is taken once the block is back in idle after the
//    result leaves, so no request is taken before the last one is done;
//    the shared serial multiplier and divider set the pace
//  - only one request is in work at a time; in.ready is low while busy
//  - the result waits in an output register; a stalled receiver only holds
//    the block in its output state, nothing is lost
//  - reset clears the matrix to zero and sets 1920 x 1080
//  - FRAC_BITS sets the fixed point fraction width (8 to 24)
module world_to_screen_projection
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]    cfg_data,
	wsp_if.sink                 in_ch,
	wsp_if.source               out_ch
);
	localparam int P_W   = 2 * WORD_W;          // exact product
	localparam int ACC_W = P_W - FRAC_BITS + 3;  // clip sum width
	localparam int N_W   = ACC_W + FRAC_BITS;    // shifted numerator
	localparam logic signed [ACC_W-1:0] W_MIN =
		ACC_W'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
	localparam logic signed [P_W-1:0] SAT_MAX = P_W'(64'sh7FFF_FFFF);
	localparam logic signed [P_W-1:0] SAT_MIN = -P_W'(64'sh8000_0000);

	// matrix store with per-entry valid bits (reset reads as zero)
	logic [WORD_W-1:0] mat_q [16];
	logic [15:0]       mat_vld_q;

	logic [CFG_W-1:0] view_w_q, view_h_q;
	state_t state_q, state_d;

	logic [3:0]  step_q;          // 0..8 multiply step index
	logic signed [ACC_W-1:0] cx_q, cy_q, cw_q;
	logic signed [WORD_W-1:0] px_q, py_q, pz_q;
	logic signed [WORD_W-1:0] nx_q, ny_q;
	logic        vis_q;
	logic signed [WORD_W-1:0] sx_q, sy_q;

	// multiplier hookup
	logic mul_start, mul_done;
	logic signed [WORD_W-1:0] mul_a, mul_b;
	logic signed [P_W-1:0] mul_p;
	logic signed [P_W-FRAC_BITS-1:0] mul_floor;

	// divider hookup
	logic div_start, div_done;
	logic [N_W-1:0] div_num, div_q;
	logic [ACC_W-1:0] div_den;
	logic num_neg;
	logic signed [ACC_W-1:0] num_sel;
	logic [ACC_W-1:0] num_mag;

	wsp_serial_mul #(.A_W(WORD_W), .B_W(WORD_W)) u_mul (
		.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	wsp_serial_div #(.N_W(N_W), .D_W(ACC_W)) u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_q)
	);

	// matrix entry for multiply step: rows 0,1,3 columns 0..2
	logic [1:0] row_sel, col_sel;
	logic [3:0] ent_idx;
	logic [3:0] tr_idx;
	logic signed [WORD_W-1:0] ent_val, tr_val;

	always_comb begin
		if (step_q inside {[4'd0:4'd2]})
			row_sel = 2'd0;
		else if (step_q inside {[4'd3:4'd5]})
			row_sel = 2'd1;
		else
			row_sel = 2'd3;
		if (step_q inside {4'd0, 4'd3, 4'd6})
			col_sel = 2'd0;
		else if (step_q inside {4'd1, 4'd4, 4'd7})
			col_sel = 2'd1;
		else
			col_sel = 2'd2;
		ent_idx = {row_sel, col_sel};
		tr_idx  = {row_sel, 2'd3};
		ent_val = mat_vld_q[ent_idx] ? mat_q[ent_idx] : '0;
		tr_val  = mat_vld_q[tr_idx] ? mat_q[tr_idx] : '0;
	end

	// operand select for the shared multiplier
	logic [CFG_W-2:0] half_w, half_h;
	assign half_w = view_w_q[CFG_W-1:1];
	assign half_h = view_h_q[CFG_W-1:1];

	always_comb begin
		mul_a = ent_val;
		case (col_sel)
			2'd0:    mul_b = px_q;
			2'd1:    mul_b = py_q;
			default: mul_b = pz_q;
		endcase
		if (state_q == ST_SCALE_X_LOAD) begin
			mul_a = WORD_W'(signed'({1'b0, half_w}));
			mul_b = nx_q;
		end else if (state_q == ST_SCALE_Y_LOAD) begin
			mul_a = WORD_W'(signed'({1'b0, half_h}));
			mul_b = ny_q;
		end
	end

	assign mul_floor = mul_p[P_W-1:FRAC_BITS];
	assign mul_start = (state_q == ST_MAC_LOAD) || (state_q == ST_SCALE_X_LOAD)
		|| (state_q == ST_SCALE_Y_LOAD);

	// divider operands: magnitude of clip value, shifted
	always_comb begin
		num_sel = (state_q == ST_DIV_Y_LOAD) ? cy_q : cx_q;
		num_neg = num_sel[ACC_W-1];
		num_mag = num_neg ? ACC_W'(-num_sel) : ACC_W'(num_sel);
		div_num = {num_mag, FRAC_BITS'(0)};
		div_den = cw_q;
	end
	assign div_start = (state_q == ST_DIV_X_LOAD) || (state_q == ST_DIV_Y_LOAD);

	// saturated signed quotient
	logic neg_div_q;
	logic signed [WORD_W-1:0] quo_sat;
	always_comb begin
		if (neg_div_q)
			quo_sat = (div_q >= N_W'(64'h8000_0000)) ? WORD_W'(32'h8000_0000)
				: WORD_W'(-div_q);
		else
			quo_sat = (div_q >= N_W'(64'h7FFF_FFFF)) ? WORD_W'(32'h7FFF_FFFF)
				: WORD_W'(div_q);
	end

	// viewport offset and saturation
	logic signed [P_W-1:0] off_w, off_h, scr_x, scr_y;
	logic signed [WORD_W-1:0] scr_x_sat, scr_y_sat;
	always_comb begin
		off_w = P_W'({1'b0, half_w}) <<< FRAC_BITS;
		off_h = P_W'({1'b0, half_h}) <<< FRAC_BITS;
		scr_x = mul_p + off_w;
		scr_y = off_h - mul_p;
		scr_x_sat = (scr_x > SAT_MAX) ? WORD_W'(SAT_MAX)
			: (scr_x < SAT_MIN) ? WORD_W'(SAT_MIN) : WORD_W'(scr_x);
		scr_y_sat = (scr_y > SAT_MAX) ? WORD_W'(SAT_MAX)
			: (scr_y < SAT_MIN) ? WORD_W'(SAT_MIN) : WORD_W'(scr_y);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_ch.valid && in_ch.data.op == OP_PROJECT)
					state_d = ST_MAC_LOAD;
			ST_MAC_LOAD: state_d = ST_MAC;
			ST_MAC:
				if (mul_done)
					state_d = ST_MAC_DONE;
			ST_MAC_DONE:
				state_d = (step_q == 4'd8) ? ST_CHECK : ST_MAC_LOAD;
			ST_CHECK:
				state_d = (cw_q < W_MIN) ? ST_OUT : ST_DIV_X_LOAD;
			ST_DIV_X_LOAD: state_d = ST_DIV_X;
			ST_DIV_X:
				if (div_done)
					state_d = ST_DIV_Y_LOAD;
			ST_DIV_Y_LOAD: state_d = ST_DIV_Y;
			ST_DIV_Y:
				if (div_done)
					state_d = ST_SCALE_X_LOAD;
			ST_SCALE_X_LOAD: state_d = ST_SCALE_X;
			ST_SCALE_X:
				if (mul_done)
					state_d = ST_SCALE_Y_LOAD;
			ST_SCALE_Y_LOAD: state_d = ST_SCALE_Y;
			ST_SCALE_Y:
				if (mul_done)
					state_d = ST_OUT;
			ST_OUT:
				if (out_ch.ready)
					state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready          = (state_q == ST_IDLE);
		out_ch.valid         = (state_q == ST_OUT);
		out_ch.data.visible  = vis_q;
		out_ch.data.screen_x = sx_q;
		out_ch.data.screen_y = sy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mat_vld_q <= '0;
			view_w_q  <= VIEW_WIDTH_RST;
			view_h_q  <= VIEW_HEIGHT_RST;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_VIEW_WIDTH:  view_w_q <= cfg_data;
					REG_VIEW_HEIGHT: view_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && in_ch.valid && in_ch.data.op == OP_LOAD)
				mat_vld_q[in_ch.data.entry_index] <= 1'b1;
			if (state_q == ST_IDLE)
				step_q <= '0;
			else if (state_q == ST_MAC_DONE)
				step_q <= step_q + 4'd1;
		end
	end

	// matrix writes, operand capture and datapath registers
	logic signed [ACC_W-1:0] acc_add;
	assign acc_add = ACC_W'(mul_floor);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			if (in_ch.data.op == OP_LOAD)
				mat_q[in_ch.data.entry_index] <= in_ch.data.entry_value;
			px_q <= in_ch.data.pos_x;
			py_q <= in_ch.data.pos_y;
			pz_q <= in_ch.data.pos_z;
		end
		if (state_q == ST_MAC_DONE) begin
			// first column of each row starts from the translation entry
			case (step_q)
				4'd0: cx_q <= ACC_W'(tr_val) + acc_add;
				4'd1, 4'd2: cx_q <= cx_q + acc_add;
				4'd3: cy_q <= ACC_W'(tr_val) + acc_add;
				4'd4, 4'd5: cy_q <= cy_q + acc_add;
				4'd6: cw_q <= ACC_W'(tr_val) + acc_add;
				default: cw_q <= cw_q + acc_add;
			endcase
		end
		if (state_q == ST_CHECK) begin
			vis_q <= !(cw_q < W_MIN);
			sx_q  <= '0;
			sy_q  <= '0;
		end
		if (div_start)
			neg_div_q <= num_neg;
		if (state_q == ST_DIV_X && div_done)
			nx_q <= quo_sat;
		if (state_q == ST_DIV_Y && div_done)
			ny_q <= quo_sat;
		if (state_q == ST_SCALE_X && mul_done)
			sx_q <= scr_x_sat;
		if (state_q == ST_SCALE_Y && mul_done)
			sy_q <= scr_y_sat;
	end

	// result only offered from its own state, and input closed meanwhile
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input open while result pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("result dropped under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.data.visible) |->
		(out_ch.data.screen_x == '0 && out_ch.data.screen_y == '0))
		else $error("hidden point with nonzero screen position");
endmodule
